// File: design/srpc_pkg.sv
`timescale 1ns / 1ps

package srpc_pkg;

  // Widths of the request fields.
  localparam int unsigned STEP_W = 7;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CHAN_W = 8;

  // Register map: one register, decoded on the word index bit of paddr.
  localparam int unsigned        APB_DATA_W     = 32;
  localparam int unsigned        APB_ADDR_W     = 3;
  localparam logic               CENTER_LED_IDX = 1'b0;
  localparam logic [IDX_W-1:0]   CENTER_LED_RST = 5'd18;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // Result word as it travels on the output tdata, red in the lowest byte.
  typedef struct packed {
    logic [CHAN_W-1:0] fill_level;
    rgb_t              color;
  } pix_t;

  // Input word, step in the lowest bits.
  typedef struct packed {
    logic [3:0]       pad;
    logic [IDX_W-1:0] led_index;
    logic [STEP_W-1:0] step;
  } req_t;

endpackage

// File: design/sunrise_ring_pixel_color.sv
`timescale 1ns / 1ps

// Sunrise ring pixel colour generator. Each request carries an animation step and an LED
// index; the block answers with that LED's red, green and blue levels and the mono ring fill
// level. It accepts one request every clock while not stalled and delivers its result
// through a three-stage pipeline: stage one looks the step up in constant tables (palette
// colour, edge colour, arc radius, fill level) and folds both indices onto the ring, stage
// two forms the circular distance to the centre LED, and stage three selects full, edge or
// dark colour into the output register. Backpressure on the output stalls the stages that
// are full only, so empty stages keep filling. The centre LED is set through the APB
// register at byte address 0 and should be written while no request is in flight.
module sunrise_ring_pixel_color #(
  parameter int unsigned RING_SIZE = 24,
  parameter int unsigned STEPS     = 80
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream; tdata from bit 0: step[6:0], led_index[11:7], zero padding[15:12].
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [15:0]                       s_axis_tdata_i,
  // Output stream; tdata from bit 0: red[7:0], green[15:8], blue[23:16], fill_level[31:24].
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srpc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srpc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srpc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned RingW  = $clog2(RING_SIZE);
  localparam int unsigned RadMax = RING_SIZE / 2 + 1;
  localparam int unsigned DistW  = $clog2(RadMax + 1);
  localparam int unsigned StepN  = 2 ** srpc_pkg::STEP_W;
  localparam int unsigned IdxN   = 2 ** srpc_pkg::IDX_W;
  localparam int unsigned Half   = STEPS / 2;
  localparam int unsigned ThreeQ = (STEPS * 3) / 4;
  localparam int unsigned Span   = STEPS / 4;
  localparam logic [RingW:0] RingSz = RING_SIZE[RingW:0];

  // ---------------------------------------------------------------------------------------
  // Constant tables, worked out at elaboration for every step and index value.
  // ---------------------------------------------------------------------------------------
  function automatic srpc_pkg::rgb_t palette_f(int unsigned s);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    srpc_pkg::rgb_t c;
    if (s == 0) begin
      r = 0; g = 0; b = 0;
    end else if (s >= STEPS) begin
      r = 255; g = 180; b = 30;
    end else if (s < Half) begin
      r = (s * 510) / STEPS; g = 0; b = 0;
    end else if (s < ThreeQ) begin
      r = 255; g = ((s - Half) * 120) / Span; b = 0;
    end else begin
      r = 255; g = 120 + ((s - ThreeQ) * 60) / Span; b = ((s - ThreeQ) * 30) / Span;
    end
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    return c;
  endfunction

  function automatic srpc_pkg::rgb_t edge_f(int unsigned s);
    int unsigned frac;
    srpc_pkg::rgb_t c;
    srpc_pkg::rgb_t e;
    c    = palette_f(s);
    frac = (s * RadMax) % STEPS;
    e.red   = 8'((int'(c.red) * frac) / STEPS);
    e.green = 8'((int'(c.green) * frac) / STEPS);
    e.blue  = 8'((int'(c.blue) * frac) / STEPS);
    return e;
  endfunction

  // Whole radius, clamped just above the largest ring distance so that compares still hold.
  function automatic logic [DistW-1:0] radius_f(int unsigned s);
    int unsigned full;
    full = (s * RadMax) / STEPS;
    if (full > RadMax) begin
      full = RadMax;
    end
    return DistW'(full);
  endfunction

  function automatic logic [7:0] fill_f(int unsigned s);
    int unsigned f;
    f = (s * 255) / STEPS;
    if (f > 255) begin
      f = 255;
    end
    return 8'(f);
  endfunction

  srpc_pkg::rgb_t   full_tab [StepN];
  srpc_pkg::rgb_t   edge_tab [StepN];
  logic [DistW-1:0] rad_tab  [StepN];
  logic [7:0]       fill_tab [StepN];
  logic [RingW-1:0] mod_tab  [IdxN];

  for (genvar gi = 0; gi < StepN; gi++) begin : g_step_tab
    assign full_tab[gi] = palette_f(gi);
    assign edge_tab[gi] = edge_f(gi);
    assign rad_tab[gi]  = radius_f(gi);
    assign fill_tab[gi] = fill_f(gi);
  end

  for (genvar gi = 0; gi < IdxN; gi++) begin : g_mod_tab
    assign mod_tab[gi] = RingW'(gi % RING_SIZE);
  end

  // ---------------------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------------------
  logic [srpc_pkg::IDX_W-1:0] center_led_q;
  logic [srpc_pkg::IDX_W-1:0] center_led_d;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == srpc_pkg::CENTER_LED_IDX);

  always_comb begin
    center_led_d = center_led_q;
    if (cfg_wr) begin
      center_led_d = pwdata[srpc_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_led_q <= srpc_pkg::CENTER_LED_RST;
    end else begin
      center_led_q <= center_led_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == srpc_pkg::CENTER_LED_IDX) begin
      prdata = {{(srpc_pkg::APB_DATA_W - srpc_pkg::IDX_W){1'b0}}, center_led_q};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control: a stage takes new data when it is empty or its successor moves on.
  // ---------------------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_valid_d, s2_valid_d, s3_valid_d;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy = !s3_valid_q || m_axis_tready_i;
  assign s2_rdy = !s2_valid_q || s3_rdy;
  assign s1_rdy = !s1_valid_q || s2_rdy;

  assign s_axis_tready_o = s1_rdy;
  assign m_axis_tvalid_o = s3_valid_q;

  assign s1_valid_d = s1_rdy ? s_axis_tvalid_i : s1_valid_q;
  assign s2_valid_d = s2_rdy ? s1_valid_q : s2_valid_q;
  assign s3_valid_d = s3_rdy ? s2_valid_q : s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: table look-ups by step, indices folded onto the ring.
  // ---------------------------------------------------------------------------------------
  srpc_pkg::req_t   req;
  srpc_pkg::rgb_t   s1_full_q, s1_edge_q, s1_full_d, s1_edge_d;
  logic [DistW-1:0] s1_rad_q, s1_rad_d;
  logic [7:0]       s1_fill_q, s1_fill_d;
  logic [RingW-1:0] s1_idx_q, s1_ctr_q, s1_idx_d, s1_ctr_d;

  assign req       = srpc_pkg::req_t'(s_axis_tdata_i);
  assign s1_full_d = full_tab[req.step];
  assign s1_edge_d = edge_tab[req.step];
  assign s1_rad_d  = rad_tab[req.step];
  assign s1_fill_d = fill_tab[req.step];
  assign s1_idx_d  = mod_tab[req.led_index];
  assign s1_ctr_d  = mod_tab[center_led_q];

  always_ff @(posedge clk_i) begin
    if (s1_rdy && s_axis_tvalid_i) begin
      s1_full_q <= s1_full_d;
      s1_edge_q <= s1_edge_d;
      s1_rad_q  <= s1_rad_d;
      s1_fill_q <= s1_fill_d;
      s1_idx_q  <= s1_idx_d;
      s1_ctr_q  <= s1_ctr_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: circular distance between the LED and the centre.
  // ---------------------------------------------------------------------------------------
  srpc_pkg::rgb_t   s2_full_q, s2_edge_q;
  logic [DistW-1:0] s2_rad_q;
  logic [7:0]       s2_fill_q;
  logic [DistW-1:0] s2_dist_q, s2_dist_d;
  logic [RingW-1:0] diff;
  logic [RingW:0]   diff_w, wrap_w, dist_w;

  assign diff   = (s1_idx_q >= s1_ctr_q) ? (s1_idx_q - s1_ctr_q) : (s1_ctr_q - s1_idx_q);
  assign diff_w = {1'b0, diff};
  assign wrap_w = RingSz - diff_w;
  assign dist_w = (diff_w < wrap_w) ? diff_w : wrap_w;
  assign s2_dist_d = dist_w[DistW-1:0];

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_valid_q) begin
      s2_full_q <= s1_full_q;
      s2_edge_q <= s1_edge_q;
      s2_rad_q  <= s1_rad_q;
      s2_fill_q <= s1_fill_q;
      s2_dist_q <= s2_dist_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: full colour inside the arc, scaled colour on its edge, dark beyond.
  // ---------------------------------------------------------------------------------------
  srpc_pkg::pix_t s3_pix_q, s3_pix_d;

  always_comb begin
    s3_pix_d.fill_level = s2_fill_q;
    if (s2_dist_q < s2_rad_q) begin
      s3_pix_d.color = s2_full_q;
    end else if (s2_dist_q == s2_rad_q) begin
      s3_pix_d.color = s2_edge_q;
    end else begin
      s3_pix_d.color = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_valid_q) begin
      s3_pix_q <= s3_pix_d;
    end
  end

  assign m_axis_tdata_o = s3_pix_q;

endmodule

// File: design/srpc_checker.sv
`timescale 1ns / 1ps

module srpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [31:0]                     m_axis_tdata_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [srpc_pkg::APB_ADDR_W-1:0] paddr,
  input logic [srpc_pkg::APB_DATA_W-1:0] pwdata,
  input logic [srpc_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready
);

  srpc_pkg::pix_t pix;

  assign pix = srpc_pkg::pix_t'(m_axis_tdata_o);

  // A stalled result keeps its data until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output request changed while stalled");

  // With the output side ready, every stage drains, so the input must be ready too.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled although the output is ready");

  // The palette and its scaling never let green exceed red or blue exceed green, and keep blue at or below 30.
  a_colour_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pix.color.green <= pix.color.red) &&
                        (pix.color.blue <= pix.color.green) && (pix.color.blue <= 8'd30))
    else $error("colour outside the palette");

  // A write to the centre register reads back on the following cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == srpc_pkg::CENTER_LED_IDX))
      ##1 (paddr[2] == srpc_pkg::CENTER_LED_IDX)
      |-> prdata[srpc_pkg::IDX_W-1:0] == $past(pwdata[srpc_pkg::IDX_W-1:0]))
    else $error("centre register read-back mismatch");

endmodule

bind sunrise_ring_pixel_color srpc_checker u_srpc_checker (.*);
